@@ hw/rtl/dwm_pkg.sv @@
// Package for the distinct-window marker detector: widths, codes and the
// structs passed between the window tracker and the last-seen table.
// No dependencies.
`default_nettype none

package dwm_pkg;

  localparam int WINDOW_MAX_DEF = 16;
  localparam int SYM_W          = 8;
  localparam int NUM_SYM        = 1 << SYM_W;
  localparam int POS_W          = 16;
  localparam int WLEN_W         = 5;
  localparam int STAMP_W        = 10;
  localparam int DATA_W         = 32;
  localparam int PADDR_W        = 3;

  localparam logic [SYM_W-1:0]  NEWLINE_SYM    = 8'd10;
  localparam logic [WLEN_W-1:0] WINDOW_LEN_RST = 5'd14;
  localparam logic [POS_W-1:0]  POS_MAX        = 16'hFFFF;

  typedef enum logic [0:0] {
    REG_WINDOW_LEN = 1'b0
  } reg_idx_e;

  typedef logic [STAMP_W-1:0] stamp_t;

  typedef struct packed {
    logic             en;
    logic [SYM_W-1:0] addr;
    stamp_t           stamp;
  } tbl_wr_t;

  typedef struct packed {
    logic   valid;
    stamp_t stamp;
  } tbl_hit_t;

endpackage

`default_nettype wire

@@ hw/rtl/dwm_stream_ifs.sv @@
// Valid/ready stream interfaces: byte beats in, marker position beats out.
// Depends on dwm_pkg.
`default_nettype none

interface dwm_sym_if;
  logic                     valid;
  logic                     ready;
  logic [dwm_pkg::SYM_W-1:0] symbol;
  modport source (output valid, output symbol, input ready);
  modport sink   (input valid, input symbol, output ready);
endinterface

interface dwm_pos_if;
  logic                     valid;
  logic                     ready;
  logic [dwm_pkg::POS_W-1:0] marker_position;
  modport source (output valid, output marker_position, input ready);
  modport sink   (input valid, input marker_position, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/dwm_apb_regs.sv @@
// APB-style register port holding window_len.
// Depends on dwm_pkg.
`default_nettype none

module dwm_apb_regs (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [dwm_pkg::PADDR_W-1:0] paddr,
  input  wire logic [dwm_pkg::DATA_W-1:0]  pwdata,
  output logic      [dwm_pkg::DATA_W-1:0]  prdata,
  output logic                             pready,
  output logic      [dwm_pkg::WLEN_W-1:0]  window_len_o
);

  logic [dwm_pkg::WLEN_W-1:0] wlen_q, wlen_d;
  logic                       hit_wlen;

  assign pready   = 1'b1;
  assign hit_wlen = (paddr[dwm_pkg::PADDR_W-1] == dwm_pkg::REG_WINDOW_LEN);

  always_comb begin
    wlen_d = wlen_q;
    if (psel && penable && pwrite && pready && hit_wlen) begin
      wlen_d = pwdata[dwm_pkg::WLEN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q <= dwm_pkg::WINDOW_LEN_RST;
    end else begin
      wlen_q <= wlen_d;
    end
  end

  assign prdata       = hit_wlen ? dwm_pkg::DATA_W'(wlen_q) : '0;
  assign window_len_o = wlen_q;

endmodule

`default_nettype wire

@@ hw/rtl/dwm_seen_table.sv @@
// Last-seen table: per byte value, the stamp of its latest beat in the line.
// Synchronous RAM with forwarding, valid flops and a background age sweep.
// Depends on dwm_pkg.
`default_nettype none

module dwm_seen_table (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      rd_en_i,
  input  wire logic [dwm_pkg::SYM_W-1:0] rd_addr_i,
  input  wire logic [dwm_pkg::SYM_W-1:0] lk_addr_i,
  input  wire dwm_pkg::tbl_wr_t          wr_i,
  input  wire logic                      clear_i,
  input  wire dwm_pkg::stamp_t           now_i,
  output dwm_pkg::tbl_hit_t              hit_o
);

  dwm_pkg::stamp_t mem_q [dwm_pkg::NUM_SYM];

  dwm_pkg::stamp_t rd_q;
  dwm_pkg::stamp_t fwd_stamp_q;
  logic            fwd_q;

  logic [dwm_pkg::NUM_SYM-1:0] vld_q, vld_d;

  logic [dwm_pkg::SYM_W-1:0] sweep_q;
  logic [dwm_pkg::SYM_W-1:0] sweep_addr_q;
  logic                      sweep_hit_q;
  dwm_pkg::stamp_t           sweep_data_q;
  dwm_pkg::stamp_t           sweep_age;
  logic                      sweep_stale;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.stamp;
    end
    if (rd_en_i) begin
      rd_q        <= mem_q[rd_addr_i];
      fwd_stamp_q <= wr_i.stamp;
    end
    sweep_data_q <= mem_q[sweep_q];
  end

  // entries past half the stamp range can no longer be told apart; drop them
  assign sweep_age   = now_i - sweep_data_q;
  assign sweep_stale = sweep_age[dwm_pkg::STAMP_W-1];

  always_comb begin
    vld_d = vld_q;
    if (clear_i) begin
      vld_d = '0;
    end else if (vld_q[sweep_addr_q] && sweep_stale && !sweep_hit_q) begin
      vld_d[sweep_addr_q] = 1'b0;
    end
    if (wr_i.en) begin
      vld_d[wr_i.addr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q        <= '0;
      fwd_q        <= 1'b0;
      sweep_q      <= '0;
      sweep_addr_q <= '0;
      sweep_hit_q  <= 1'b0;
    end else begin
      vld_q        <= vld_d;
      sweep_q      <= sweep_q + 1'b1;
      sweep_addr_q <= sweep_q;
      sweep_hit_q  <= wr_i.en && (wr_i.addr == sweep_q);
      if (rd_en_i) begin
        fwd_q <= wr_i.en && (wr_i.addr == rd_addr_i);
      end
    end
  end

  assign hit_o.valid = vld_q[lk_addr_i];
  assign hit_o.stamp = fwd_q ? fwd_stamp_q : rd_q;

endmodule

`default_nettype wire

@@ hw/rtl/dwm_window_track.sv @@
// Window tracker: distinct-suffix run length, line position, found flag and
// the output register. Drives table writes and line clears.
// Depends on dwm_pkg.
`default_nettype none

module dwm_window_track #(
  parameter int WINDOW_MAX = dwm_pkg::WINDOW_MAX_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       en_i,
  input  wire logic                       accept_i,
  input  wire logic [dwm_pkg::SYM_W-1:0]  symbol_i,
  input  wire logic [dwm_pkg::WLEN_W-1:0] window_len_i,
  input  wire dwm_pkg::tbl_hit_t          hit_i,
  output dwm_pkg::tbl_wr_t                wr_o,
  output logic                            clear_o,
  output logic      [dwm_pkg::SYM_W-1:0]  lk_addr_o,
  output dwm_pkg::stamp_t                 now_o,
  output logic                            res_valid_o,
  output logic      [dwm_pkg::POS_W-1:0]  res_pos_o
);

  localparam int SW = $clog2(WINDOW_MAX + 1);
  localparam int CW = (SW > dwm_pkg::WLEN_W) ? SW : dwm_pkg::WLEN_W;

  logic                      v1_q;
  logic [dwm_pkg::SYM_W-1:0] sym1_q;
  dwm_pkg::stamp_t           stamp1_q;
  dwm_pkg::stamp_t           cnt_q;
  logic [SW-1:0]             run_q;
  logic [dwm_pkg::POS_W-1:0] pos_q;
  logic                      found_q;
  logic                      out_v_q;
  logic [dwm_pkg::POS_W-1:0] out_pos_q;

  logic                      live;
  logic                      is_nl;
  dwm_pkg::stamp_t           gap;
  logic [SW-1:0]             cand;
  logic [SW-1:0]             run_new;
  logic [CW-1:0]             wl_ext;
  logic [CW-1:0]             n_eff;
  logic [dwm_pkg::POS_W-1:0] pos_new;
  logic                      emit;

  assign live  = v1_q && en_i;
  assign is_nl = (sym1_q == dwm_pkg::NEWLINE_SYM);
  assign gap   = stamp1_q - hit_i.stamp;

  always_comb begin
    cand = (run_q == SW'(WINDOW_MAX)) ? run_q : run_q + SW'(1);
    if (hit_i.valid && (gap < dwm_pkg::STAMP_W'(cand))) begin
      run_new = gap[SW-1:0];
    end else begin
      run_new = cand;
    end
    wl_ext = CW'(window_len_i);
    if (wl_ext == '0) begin
      n_eff = CW'(1);
    end else if (wl_ext > CW'(WINDOW_MAX)) begin
      n_eff = CW'(WINDOW_MAX);
    end else begin
      n_eff = wl_ext;
    end
    pos_new = (pos_q == dwm_pkg::POS_MAX) ? pos_q : pos_q + 1'b1;
    emit    = !found_q && (CW'(run_new) >= n_eff);
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      sym1_q   <= symbol_i;
      stamp1_q <= cnt_q;
    end
    if (en_i) begin
      out_pos_q <= pos_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      cnt_q   <= '0;
      run_q   <= '0;
      pos_q   <= '0;
      found_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (accept_i && (symbol_i != dwm_pkg::NEWLINE_SYM)) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (en_i) begin
        v1_q    <= accept_i;
        out_v_q <= live && !is_nl && emit;
      end
      if (live) begin
        if (is_nl) begin
          run_q   <= '0;
          pos_q   <= '0;
          found_q <= 1'b0;
        end else begin
          run_q   <= run_new;
          pos_q   <= pos_new;
          found_q <= found_q || emit;
        end
      end
    end
  end

  assign wr_o.en     = live && !is_nl;
  assign wr_o.addr   = sym1_q;
  assign wr_o.stamp  = stamp1_q;
  assign clear_o     = live && is_nl;
  assign lk_addr_o   = sym1_q;
  assign now_o       = cnt_q;
  assign res_valid_o = out_v_q;
  assign res_pos_o   = out_pos_q;

endmodule

`default_nettype wire

@@ hw/rtl/distinct_window_marker_detector.sv @@
// Distinct-window marker detector, top level.
// Byte beats enter on sym_i (valid/ready, field symbol); one beat leaves on
// pos_o (field marker_position) the first time the last window_len bytes of
// a line are pairwise distinct. Byte 10 ends the line and gives no beat.
// window_len sits at byte address 0 of the APB-style port (pready always
// high); write it only while the block is idle.
// Throughput: one byte per cycle while pos_o is not stalled, set by the
// single-ported write of the last-seen table, which is read and written for every byte.
// Results pass the byte register sym1_q, then the output register out_v_q.
// A stalled pos_o beat holds the pipeline: sym_i.ready follows
// !pos_o.valid || pos_o.ready, so up to one further byte waits inside.
// Reset clears line state, the table valid flags and sets window_len to 14;
// the table RAM itself needs no clearing pass.
// Depends on dwm_pkg, dwm_stream_ifs, dwm_apb_regs, dwm_seen_table,
// dwm_window_track.
`default_nettype none

module distinct_window_marker_detector #(
  parameter int WINDOW_MAX = dwm_pkg::WINDOW_MAX_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  dwm_sym_if.sink                          sym_i,
  dwm_pos_if.source                        pos_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [dwm_pkg::PADDR_W-1:0] paddr,
  input  wire logic [dwm_pkg::DATA_W-1:0]  pwdata,
  output logic      [dwm_pkg::DATA_W-1:0]  prdata,
  output logic                             pready
);

  logic                       en;
  logic                       accept;
  logic                       res_valid;
  logic [dwm_pkg::POS_W-1:0]  res_pos;
  logic [dwm_pkg::WLEN_W-1:0] window_len;
  logic [dwm_pkg::SYM_W-1:0]  lk_addr;
  logic                       clear;
  dwm_pkg::tbl_wr_t           wr;
  dwm_pkg::tbl_hit_t          hit;
  dwm_pkg::stamp_t            now;

  assign en          = !res_valid || pos_o.ready;
  assign sym_i.ready = en;
  assign accept      = sym_i.valid && en;

  dwm_apb_regs u_regs (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .window_len_o (window_len)
  );

  dwm_seen_table u_table (
    .clk_i,
    .rst_ni,
    .rd_en_i   (accept),
    .rd_addr_i (sym_i.symbol),
    .lk_addr_i (lk_addr),
    .wr_i      (wr),
    .clear_i   (clear),
    .now_i     (now),
    .hit_o     (hit)
  );

  dwm_window_track #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_track (
    .clk_i,
    .rst_ni,
    .en_i         (en),
    .accept_i     (accept),
    .symbol_i     (sym_i.symbol),
    .window_len_i (window_len),
    .hit_i        (hit),
    .wr_o         (wr),
    .clear_o      (clear),
    .lk_addr_o    (lk_addr),
    .now_o        (now),
    .res_valid_o  (res_valid),
    .res_pos_o    (res_pos)
  );

  assign pos_o.valid           = res_valid;
  assign pos_o.marker_position = res_pos;

  a_clear_excl_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(clear && wr.en))
    else $error("line clear and table write in the same cycle");

  a_result_from_byte : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid) |-> $past(wr.en))
    else $error("result raised without a byte leaving the pipeline");

  a_write_when_enabled : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr.en || clear) |-> en)
    else $error("state update while the output is stalled");

  a_position_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> (res_pos != '0))
    else $error("marker position of zero");

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the distinct-window marker detector: directed rows, then
// random lines under three idling patterns, checked beat by beat against a predictor.
// Depends on dwm_pkg, dwm_stream_ifs and distinct_window_marker_detector.

module testbench;
  import dwm_pkg::*;

  localparam int WMAX = WINDOW_MAX_DEF;

  typedef enum bit [1:0] {
    ROW_WRITE,
    ROW_BYTE,
    ROW_TYPED
  } row_kind_e;

  typedef struct packed {
    row_kind_e        kind;
    logic [SYM_W-1:0] val;
    bit               hit;
    logic [POS_W-1:0] pos;
  } row_t;

  localparam int N_ROWS = 25;

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [DATA_W-1:0]  pwdata;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  dwm_sym_if sym_if ();
  dwm_pos_if pos_if ();

  distinct_window_marker_detector #(.WINDOW_MAX(WMAX)) uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .sym_i   (sym_if.sink),
    .pos_o   (pos_if.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predictor state
  logic [SYM_W-1:0]  recent_syms [WMAX];
  logic [POS_W-1:0]  line_count;
  logic              seen_marker;
  logic [WLEN_W-1:0] window_len;
  logic [POS_W-1:0]  pending_positions [$];

  int errors;
  int bytes_sent;
  int lines_sent;
  int markers_checked;
  int settings_used;
  int src_idle_pct;
  int snk_idle_pct;

  row_t directed_rows [N_ROWS] = '{
    '{ROW_TYPED, NEWLINE_SYM, 1'b0, 16'd0},
    '{ROW_TYPED, 8'd0,        1'b0, 16'd0},  // shorter than the reset window
    '{ROW_TYPED, NEWLINE_SYM, 1'b0, 16'd0},
    '{ROW_WRITE, 8'd1,        1'b0, 16'd0},
    '{ROW_TYPED, 8'd0,        1'b1, 16'd1},
    '{ROW_TYPED, 8'd0,        1'b0, 16'd0},  // marker already found
    '{ROW_TYPED, NEWLINE_SYM, 1'b0, 16'd0},
    '{ROW_WRITE, 8'd0,        1'b0, 16'd0},  // zero length acts as one
    '{ROW_TYPED, 8'd255,      1'b1, 16'd1},
    '{ROW_TYPED, NEWLINE_SYM, 1'b0, 16'd0},
    '{ROW_WRITE, 8'd2,        1'b0, 16'd0},
    '{ROW_TYPED, 8'd7,        1'b0, 16'd0},
    '{ROW_TYPED, 8'd7,        1'b0, 16'd0},
    '{ROW_TYPED, 8'd8,        1'b1, 16'd3},
    '{ROW_TYPED, NEWLINE_SYM, 1'b0, 16'd0},
    '{ROW_WRITE, 8'd4,        1'b0, 16'd0},
    '{ROW_BYTE,  8'd1,        1'b0, 16'd0},
    '{ROW_BYTE,  8'd2,        1'b0, 16'd0},
    '{ROW_BYTE,  8'd1,        1'b0, 16'd0},
    '{ROW_WRITE, 8'd2,        1'b0, 16'd0},  // shrink mid-line
    '{ROW_TYPED, 8'd3,        1'b1, 16'd4},
    '{ROW_BYTE,  NEWLINE_SYM, 1'b0, 16'd0},
    '{ROW_WRITE, 8'd31,       1'b0, 16'd0},  // saturates to the maximum window
    '{ROW_BYTE,  8'h5A,       1'b0, 16'd0},
    '{ROW_BYTE,  NEWLINE_SYM, 1'b0, 16'd0}
  };

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("distinct_window_marker_detector regression: fail");
    $finish;
  end

  function automatic void clear_line();
    foreach (recent_syms[i]) recent_syms[i] = '0;
    line_count  = '0;
    seen_marker = 1'b0;
  endfunction

  function automatic bit advance_line(input logic [SYM_W-1:0] sym,
                                      output logic [POS_W-1:0] pos);
    int span;
    bit all_differ;
    pos = '0;
    if (sym == NEWLINE_SYM) begin
      clear_line();
      return 1'b0;
    end
    for (int k = WMAX - 1; k > 0; k--) recent_syms[k] = recent_syms[k-1];
    recent_syms[0] = sym;
    if (line_count != POS_MAX) line_count++;
    if (seen_marker) return 1'b0;
    span = (window_len == '0) ? 1 : ((int'(window_len) > WMAX) ? WMAX : int'(window_len));
    if (int'(line_count) < span) return 1'b0;
    all_differ = 1'b1;
    for (int a = 0; a < span; a++)
      for (int b = a + 1; b < span; b++)
        if (recent_syms[a] == recent_syms[b]) all_differ = 1'b0;
    if (!all_differ) return 1'b0;
    seen_marker = 1'b1;
    pos = line_count;
    return 1'b1;
  endfunction

  task automatic send_byte(input logic [SYM_W-1:0] sym, input bit typed = 1'b0,
                           input bit typed_hit = 1'b0,
                           input logic [POS_W-1:0] typed_pos = '0);
    logic [POS_W-1:0] pos;
    bit hit;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      @(negedge clk_i);
      sym_if.valid <= 1'b0;
    end
    @(negedge clk_i);
    sym_if.valid  <= 1'b1;
    sym_if.symbol <= sym;
    do @(posedge clk_i); while (!sym_if.ready);
    hit = advance_line(sym, pos);
    if (typed) begin
      hit = typed_hit;
      pos = typed_pos;
    end
    if (hit) pending_positions.push_back(pos);
    bytes_sent++;
    if (sym == NEWLINE_SYM) lines_sent++;
  endtask

  task automatic send_line();
    int len;
    int spread;
    logic [SYM_W-1:0] base;
    logic [SYM_W-1:0] sym;
    len    = $urandom_range(1, 40);
    spread = ($urandom_range(0, 3) == 0) ? 256 : $urandom_range(1, 24);
    base   = SYM_W'($urandom);
    repeat (len) begin
      if ($urandom_range(0, 99) < 3) sym = SYM_W'($urandom);
      else sym = base + SYM_W'($urandom_range(0, spread - 1));
      send_byte(sym);
    end
    if ($urandom_range(0, 99) < 85) send_byte(NEWLINE_SYM);
  endtask

  // let the pipeline empty, including a trailing byte that gives no beat
  task automatic drain();
    @(negedge clk_i);
    sym_if.valid <= 1'b0;
    while (pending_positions.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_access(input bit wr, input logic [DATA_W-1:0] wdata,
                            output logic [DATA_W-1:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= PADDR_W'(4 * int'(REG_WINDOW_LEN));
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic read_window(input logic [WLEN_W-1:0] want);
    logic [DATA_W-1:0] rd;
    apb_access(1'b0, '0, rd);
    if (rd !== DATA_W'(want)) begin
      errors++;
      $display("%0t: window_len read expected %0d, got %0d", $time, want, rd);
    end
  endtask

  task automatic set_window(input logic [WLEN_W-1:0] len);
    logic [DATA_W-1:0] rd;
    apb_access(1'b1, DATA_W'(len), rd);
    window_len = len;
    settings_used++;
    read_window(len);
  endtask

  always @(negedge clk_i) pos_if.ready <= ($urandom_range(0, 99) >= snk_idle_pct);

  always @(posedge clk_i) begin
    if (rst_ni && pos_if.valid && pos_if.ready) begin
      markers_checked++;
      if (pending_positions.size() == 0) begin
        errors++;
        $display("%0t: marker_position expected none, got %0d", $time,
                 pos_if.marker_position);
      end else begin
        if (pos_if.marker_position !== pending_positions[0]) begin
          errors++;
          $display("%0t: marker_position expected %0d, got %0d", $time,
                   pending_positions[0], pos_if.marker_position);
        end
        void'(pending_positions.pop_front());
      end
    end
  end

  initial begin
    logic [WLEN_W-1:0] corner_lens [4];
    int target;
    int seg_end;
    int seg_no;
    corner_lens     = '{5'd0, 5'd31, 5'd1, 5'd16};
    seg_no          = 0;
    errors          = 0;
    bytes_sent      = 0;
    lines_sent      = 0;
    markers_checked = 0;
    settings_used   = 0;
    src_idle_pct    = 36;
    snk_idle_pct    = 59;
    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    sym_if.valid    = 1'b0;
    sym_if.symbol   = '0;
    pos_if.ready    = 1'b0;
    window_len      = WINDOW_LEN_RST;
    clear_line();

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    read_window(WINDOW_LEN_RST);

    foreach (directed_rows[i]) begin
      case (directed_rows[i].kind)
        ROW_WRITE: begin
          drain();
          set_window(WLEN_W'(directed_rows[i].val));
        end
        ROW_BYTE: send_byte(directed_rows[i].val);
        default:  send_byte(directed_rows[i].val, 1'b1, directed_rows[i].hit,
                            directed_rows[i].pos);
      endcase
    end

    for (int phase = 0; phase < 3; phase++) begin
      src_idle_pct = (phase == 0) ? 36 : ((phase == 1) ? 59 : 0);
      snk_idle_pct = (phase == 0) ? 59 : ((phase == 1) ? 36 : 0);
      target = bytes_sent + 533;
      while (bytes_sent < target) begin
        drain();
        if (seg_no < 4) set_window(corner_lens[seg_no]);
        else set_window(WLEN_W'($urandom));
        seg_no++;
        seg_end = bytes_sent + $urandom_range(40, 120);
        while (bytes_sent < seg_end) send_line();
      end
    end

    drain();
    $display("Covered %0d bytes, %0d line ends, %0d window settings, %0d marker beats,",
             bytes_sent, lines_sent, settings_used, markers_checked);
    $display("including window length corners and three idling patterns on both sides.");
    if (errors == 0) begin
      $display("distinct_window_marker_detector regression: pass");
    end else begin
      $display("distinct_window_marker_detector regression: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/dwm_pkg.sv
hw/rtl/dwm_stream_ifs.sv
hw/rtl/dwm_apb_regs.sv
hw/rtl/dwm_seen_table.sv
hw/rtl/dwm_window_track.sv
hw/rtl/distinct_window_marker_detector.sv
verif/testbench.sv
